// ===== rtl/qkd_pkg.sv =====
// Shared types and constants for the quadrature knob decoder.
`timescale 1ns / 1ps

package qkd_pkg;

   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int POS_W       = 8;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_BUTTON_ENABLE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_MS   = 1'b1;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd200;

   typedef enum logic [1:0] {
      OP_SAMPLE   = 2'd0,
      OP_READ_POS = 2'd1,
      OP_READ_DIR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   // Input beat, lowest field in the lowest bits.
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              pin_button;
      logic              pin_b;
      logic              pin_a;
      logic [1:0]        opcode;
   } req_item_type;

   // Result beat, lowest field in the lowest bits.
   typedef struct packed {
      logic signed [POS_W-1:0] read_value;
      logic                    select_event;
      logic                    prev_event;
      logic                    next_event;
   } rsp_item_type;

   // Detent completed by the tracker on the current sample.
   typedef struct packed {
      logic cw;
      logic ccw;
   } detent_type;

endpackage

// ===== rtl/qkd_track.sv =====
// Seven-state quadrature edge-order tracker with A/B history.
`timescale 1ns / 1ps

module qkd_track
   import qkd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       pin_a,
   input  logic       pin_b,
   output detent_type detent
);

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'd0,
      SEQ_CW1  = 3'd1,
      SEQ_CW2  = 3'd2,
      SEQ_CW3  = 3'd3,
      SEQ_CCW3 = 3'd5,
      SEQ_CCW2 = 3'd6,
      SEQ_CCW1 = 3'd7
   } seq_type;

   seq_type seq_ff;
   seq_type seq_in;
   logic    last_a_ff;
   logic    last_b_ff;
   logic    change;
   logic    pa;
   logic    pb;

   assign pa     = last_a_ff;
   assign pb     = last_b_ff;
   assign change = (pin_a != pa) || (pin_b != pb);

   always_comb begin
      seq_in    = SEQ_IDLE;
      detent.cw  = 1'b0;
      detent.ccw = 1'b0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (!pin_a && pa && pin_b && pb)
               seq_in = SEQ_CW1;
            else if (pin_a && pa && !pin_b && pb)
               seq_in = SEQ_CCW1;
         end
         SEQ_CW1: begin
            if (!pin_a && !pa && !pin_b && pb)
               seq_in = SEQ_CW2;
         end
         SEQ_CW2: begin
            if (pin_a && !pa && !pin_b && !pb)
               seq_in = SEQ_CW3;
         end
         SEQ_CW3: begin
            detent.cw = step && pin_a && pa && pin_b && !pb;
         end
         SEQ_CCW1: begin
            if (!pin_a && pa && !pin_b && !pb)
               seq_in = SEQ_CCW2;
         end
         SEQ_CCW2: begin
            if (!pin_a && !pa && pin_b && !pb)
               seq_in = SEQ_CCW3;
         end
         SEQ_CCW3: begin
            detent.ccw = step && pin_a && !pa && pin_b && pb;
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SEQ_IDLE;
         last_a_ff <= 1'b1;
         last_b_ff <= 1'b1;
      end else if (step && change) begin
         seq_ff    <= seq_in;
         last_a_ff <= pin_a;
         last_b_ff <= pin_b;
      end
   end

`ifndef ASSERT_OFF
   a_detent_to_idle: assert property (@(posedge clock) disable iff (reset)
      (detent.cw || detent.ccw) |=> (seq_ff == SEQ_IDLE))
      else $error("tracker not idle after detent");

   a_detent_one_way: assert property (@(posedge clock) disable iff (reset)
      !(detent.cw && detent.ccw))
      else $error("detent in both directions");

   a_hold_no_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(seq_ff) && $stable(last_a_ff) && $stable(last_b_ff))
      else $error("tracker moved without a sample");
`endif

endmodule

// ===== rtl/qkd_button.sv =====
// Button falling-edge detector with millisecond debounce window.
`timescale 1ns / 1ps

module qkd_button
   import qkd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  enable,
   input  logic [DEBOUNCE_W-1:0] debounce_ms,
   input  logic                  pin_button,
   input  logic [TIME_W-1:0]     now_ms,
   output logic                  fire
);

   logic              last_button_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [TIME_W-1:0] rem_in;
   logic [TIME_W-1:0] press_time_ff;
   logic [TIME_W-1:0] dt;
   logic [TIME_W:0]   diff;
   logic [TIME_W-1:0] rem_left;
   logic              falling;

   assign dt   = now_ms - press_time_ff;
   assign diff = {1'b0, rem_ff} - {1'b0, dt};

   // saturating count-down of the window by the elapsed time
   always_comb begin
      if (rem_ff == '0 || diff[TIME_W])
         rem_left = '0;
      else
         rem_left = diff[TIME_W-1:0];
   end

   assign falling = !pin_button && last_button_ff;
   assign fire    = step && enable && falling && (rem_left == '0);
   assign rem_in  = fire ? {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms} : rem_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_button_ff <= 1'b1;
         rem_ff         <= '0;
         press_time_ff  <= '0;
      end else if (step) begin
         if (!enable) begin
            last_button_ff <= 1'b1;
         end else begin
            last_button_ff <= pin_button;
            if (falling) begin
               rem_ff        <= rem_in;
               press_time_ff <= now_ms;
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_fire_reload: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rem_ff == {{(TIME_W-DEBOUNCE_W){1'b0}}, $past(debounce_ms)}))
      else $error("window not reloaded after press");

   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && !enable) |=> last_button_ff && $stable(rem_ff))
      else $error("disabled button changed state");

   a_fire_on_edge: assert property (@(posedge clock) disable iff (reset)
      fire |=> !last_button_ff)
      else $error("press without falling edge");
`endif

endmodule

// ===== rtl/quadrature_knob_decoder.sv =====
// Top level: input register, knob decode and result register.
//
//  channel | dir | beat fields (low bit first)
//  req_    | in  | opcode, pin_a, pin_b, pin_button, now_ms
//  rsp_    | out | next_event, prev_event, select_event, read_value
//  csr_    | in  | 0 button_enable, 1 debounce_ms
//
// One beat per cycle sustained while rsp_tready is high; a request beat is held in the
// input register and its result in the result register. The state update and result
// capture happen in the same cycle, between the input and output registers. rsp_tready
// low holds the result and backs up into the input register, then req_tready drops.
// Reset is synchronous and clears all tracker, count and debounce state; no clearing pass.
`timescale 1ns / 1ps

module quadrature_knob_decoder
   import qkd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // opcode, pin_a, pin_b, pin_button, now_ms
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // next_event, prev_event, select_event, read_value
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                  button_enable_ff;
   logic [DEBOUNCE_W-1:0] debounce_ms_ff;

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   rsp_item_type  out_item_in;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   dir_type          dir_ff;
   dir_type          dir_in;

   logic       advance;
   logic       sample;
   detent_type detent;
   logic       fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign sample     = advance && (in_item_ff.opcode == OP_SAMPLE);

   qkd_track u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (sample),
      .pin_a  (in_item_ff.pin_a),
      .pin_b  (in_item_ff.pin_b),
      .detent (detent)
   );

   qkd_button u_button (
      .clock       (clock),
      .reset       (reset),
      .step        (sample),
      .enable      (button_enable_ff),
      .debounce_ms (debounce_ms_ff),
      .pin_button  (in_item_ff.pin_button),
      .now_ms      (in_item_ff.now_ms),
      .fire        (fire)
   );

   always_comb begin
      out_item_in = '0;
      pos_in      = pos_ff;
      dir_in      = dir_ff;
      unique case (opcode_type'(in_item_ff.opcode))
         OP_SAMPLE: begin
            out_item_in.next_event   = detent.cw;
            out_item_in.prev_event   = detent.ccw;
            out_item_in.select_event = fire;
            if (detent.cw) begin
               pos_in = pos_ff + 1'b1;
               dir_in = DIR_CW;
            end else if (detent.ccw) begin
               pos_in = pos_ff - 1'b1;
               dir_in = DIR_CCW;
            end
         end
         OP_READ_POS: begin
            out_item_in.read_value = pos_ff;
            pos_in                 = '0;
         end
         OP_READ_DIR: begin
            unique case (dir_ff)
               DIR_CW:  out_item_in.read_value = 8'sd1;
               DIR_CCW: out_item_in.read_value = -8'sd1;
               default: out_item_in.read_value = '0;
            endcase
            dir_in = DIR_NONE;
         end
         default: begin
            out_item_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_enable_ff <= 1'b0;
         debounce_ms_ff   <= DEBOUNCE_RESET;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         pos_ff           <= '0;
         dir_ff           <= DIR_NONE;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BUTTON_ENABLE: button_enable_ff <= csr_wdata[0];
               CSR_DEBOUNCE_MS:   debounce_ms_ff   <= csr_wdata[DEBOUNCE_W-1:0];
               default:           ;
            endcase
         end
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            pos_ff       <= pos_in;
            dir_ff       <= dir_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid)
         in_item_ff <= req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
      if (advance)
         out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-$bits(rsp_item_type)){1'b0}}, out_item_ff};

`ifndef ASSERT_OFF
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_item_ff.next_event && out_item_ff.prev_event))
      else $error("both step events in one beat");

   a_read_no_events: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.opcode != OP_SAMPLE) |=>
      (!out_item_ff.next_event && !out_item_ff.prev_event && !out_item_ff.select_event))
      else $error("event on a read beat");

   a_pos_stable: assert property (@(posedge clock) disable iff (reset)
      (sample && !detent.cw && !detent.ccw) |=> $stable(pos_ff))
      else $error("position moved without a detent");

   a_pos_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.opcode == OP_READ_POS) |=> (pos_ff == '0))
      else $error("position not cleared by read");
`endif

endmodule

// ===== tb/tb_quadrature_knob_decoder.sv =====
// Self-checking testbench for the quadrature knob decoder: directed and random stream traffic.
`timescale 1ns / 1ps

module tb_quadrature_knob_decoder;
   import qkd_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam bit [2:0] TRK_IDLE = 3'd0;
   localparam bit [2:0] TRK_CW1  = 3'd1;
   localparam bit [2:0] TRK_CW2  = 3'd2;
   localparam bit [2:0] TRK_CW3  = 3'd3;
   localparam bit [2:0] TRK_CCW1 = 3'd7;
   localparam bit [2:0] TRK_CCW2 = 3'd6;
   localparam bit [2:0] TRK_CCW3 = 3'd5;

   class knob_scoreboard;
      bit           watch_button = 1'b0;
      bit [15:0]    window_ms = DEBOUNCE_RESET;
      bit [2:0]     track_state = TRK_IDLE;
      bit           prev_a = 1'b1;
      bit           prev_b = 1'b1;
      bit           prev_button = 1'b1;
      bit [7:0]     position = '0;
      dir_type      heading = DIR_NONE;
      bit [31:0]    window_left = '0;
      bit [31:0]    press_stamp = '0;
      rsp_item_type pending[$];
      int           errors = 0;

      function void write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr == CSR_BUTTON_ENABLE) watch_button = data[0];
         else if (addr == CSR_DEBOUNCE_MS) window_ms = data;
      endfunction

      function dir_type advance_tracker(bit a, bit b);
         dir_type  done;
         bit [2:0] nxt;
         done = DIR_NONE;
         nxt = TRK_IDLE;
         case (track_state)
            TRK_IDLE: begin
               if (!a && prev_a && b && prev_b) nxt = TRK_CW1;
               else if (a && prev_a && !b && prev_b) nxt = TRK_CCW1;
            end
            TRK_CW1:  if (!a && !prev_a && !b && prev_b) nxt = TRK_CW2;
            TRK_CW2:  if (a && !prev_a && !b && !prev_b) nxt = TRK_CW3;
            TRK_CW3:  if (a && prev_a && b && !prev_b) done = DIR_CW;
            TRK_CCW1: if (!a && prev_a && !b && !prev_b) nxt = TRK_CCW2;
            TRK_CCW2: if (!a && !prev_a && b && !prev_b) nxt = TRK_CCW3;
            TRK_CCW3: if (a && !prev_a && b && prev_b) done = DIR_CCW;
            default:  nxt = TRK_IDLE;
         endcase
         track_state = nxt;
         return done;
      endfunction

      function bit press_check(bit s, bit [31:0] now);
         bit        fire;
         bit [31:0] dt;
         fire = 1'b0;
         if (!watch_button) begin
            prev_button = 1'b1;
            return 1'b0;
         end
         if (s != prev_button && !s) begin
            if (window_left != 0) begin
               dt = now - press_stamp;
               if (dt > window_left) window_left = '0;
               else window_left = window_left - dt;
               press_stamp = now;
            end
            if (window_left == 0) begin
               window_left = {16'b0, window_ms};
               press_stamp = now;
               fire = 1'b1;
            end
         end
         prev_button = s;
         return fire;
      endfunction

      function void note_request(req_item_type it);
         rsp_item_type exp;
         dir_type      d;
         exp = '0;
         case (it.opcode)
            OP_SAMPLE: begin
               exp.select_event = press_check(it.pin_button, it.now_ms);
               if (it.pin_a != prev_a || it.pin_b != prev_b) begin
                  d = advance_tracker(it.pin_a, it.pin_b);
                  if (d == DIR_CW) begin
                     exp.next_event = 1'b1;
                     heading = DIR_CW;
                     position = position + 8'd1;
                  end else if (d == DIR_CCW) begin
                     exp.prev_event = 1'b1;
                     heading = DIR_CCW;
                     position = position - 8'd1;
                  end
                  prev_a = it.pin_a;
                  prev_b = it.pin_b;
               end
            end
            OP_READ_POS: begin
               exp.read_value = position;
               position = '0;
            end
            OP_READ_DIR: begin
               case (heading)
                  DIR_CW:  exp.read_value = 8'sd1;
                  DIR_CCW: exp.read_value = -8'sd1;
                  default: exp.read_value = 8'sd0;
               endcase
               heading = DIR_NONE;
            end
            default: ;
         endcase
         pending.push_back(exp);
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_response(logic [RSP_TDATA_W-1:0] raw);
         rsp_item_type got;
         rsp_item_type exp;
         got = rsp_item_type'(raw[$bits(rsp_item_type)-1:0]);
         if (pending.size() == 0) begin
            report("unexpected beat", raw, 0);
         end else begin
            exp = pending.pop_front();
            if (got.next_event !== exp.next_event)
               report("next_event", got.next_event, exp.next_event);
            if (got.prev_event !== exp.prev_event)
               report("prev_event", got.prev_event, exp.prev_event);
            if (got.select_event !== exp.select_event)
               report("select_event", got.select_event, exp.select_event);
            if (got.read_value !== exp.read_value)
               report("read_value", got.read_value, exp.read_value);
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // opcode, pin_a, pin_b, pin_button, now_ms
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // next_event, prev_event, select_event, read_value
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   knob_scoreboard meter = new();
   bit        no_idle = 1'b0;
   bit        cur_a = 1'b1;
   bit        cur_b = 1'b1;
   bit        cur_btn = 1'b1;
   bit [31:0] clock_ms = '0;
   int        stall_left = 0;

   quadrature_knob_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side backpressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) meter.check_response(rsp_tdata);
   end

   task automatic send_beat(input req_item_type it);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_W'(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      meter.note_request(it);
      @(negedge clock);
   endtask

   task automatic sample(bit a, bit b, bit s, bit [31:0] t);
      req_item_type it;
      it.opcode = OP_SAMPLE;
      it.pin_a = a;
      it.pin_b = b;
      it.pin_button = s;
      it.now_ms = t;
      send_beat(it);
   endtask

   // pins and time are don't-care on reads, so fill them randomly
   task automatic read_op(logic [1:0] op);
      req_item_type it;
      it = req_item_type'({$urandom, 5'($urandom)});
      it.opcode = op;
      send_beat(it);
   endtask

   function automatic bit [31:0] tick_ms();
      case ($urandom_range(0, 19))
         0:       clock_ms = clock_ms + $urandom_range(60000, 70000);
         1:       clock_ms = clock_ms + $urandom;
         default: clock_ms = clock_ms + $urandom_range(0, 30);
      endcase
      return clock_ms;
   endfunction

   task automatic pins(bit a, bit b);
      if ($urandom_range(0, 2) == 0) cur_btn = ~cur_btn;
      sample(a, b, cur_btn, tick_ms());
      cur_a = a;
      cur_b = b;
   endtask

   // one detent, one step randomized when broken; {a,b} per step, active low
   task automatic turn(bit cw, bit broken, bit chatty);
      logic [1:0] seq[4];
      int         bad;
      if (cw) seq = '{2'b01, 2'b00, 2'b10, 2'b11};
      else seq = '{2'b10, 2'b00, 2'b01, 2'b11};
      bad = broken ? $urandom_range(0, 3) : 4;
      for (int k = 0; k < 4; k++) begin
         if (k == bad) seq[k] = 2'($urandom);
         pins(seq[k][1], seq[k][0]);
         if (chatty) begin
            case ($urandom_range(0, 9))
               0:       read_op(OP_READ_DIR);
               1, 2:    pins(cur_a, cur_b);
               default: ;
            endcase
         end
      end
   endtask

   task automatic random_event();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) turn(1'($urandom_range(0, 1)), 1'b0, 1'b1);
      else if (r < 62) turn(1'($urandom_range(0, 1)), 1'b1, 1'b1);
      else if (r < 72) pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (r < 82) read_op(OP_READ_POS);
      else if (r < 90) read_op(OP_READ_DIR);
      else if (r < 94) read_op(OP_UNUSED);
      else begin
         cur_btn = 1'($urandom_range(0, 1));
         clock_ms = $urandom;
         sample(cur_a, cur_b, cur_btn, clock_ms);
      end
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      meter.write_csr(addr, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain(int extra);
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (meter.pending.size() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (extra) @(negedge clock);
   endtask

   task automatic run_phase(bit en, bit [15:0] ms, int events);
      drain(6);
      write_reg(CSR_BUTTON_ENABLE, CSR_DATA_W'(en));
      write_reg(CSR_DEBOUNCE_MS, ms);
      repeat (events) random_event();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(CSR_BUTTON_ENABLE, 16'd1);
      write_reg(CSR_DEBOUNCE_MS, 16'd3);
      read_op(OP_READ_POS);
      read_op(OP_READ_DIR);
      sample(1'b0, 1'b1, 1'b1, 32'd0);
      sample(1'b0, 1'b0, 1'b1, 32'd0);
      sample(1'b1, 1'b0, 1'b1, 32'd0);
      sample(1'b1, 1'b1, 1'b1, 32'd0);
      read_op(OP_READ_DIR);
      read_op(OP_READ_POS);
      sample(1'b1, 1'b0, 1'b1, 32'd1);
      sample(1'b0, 1'b0, 1'b1, 32'd1);
      sample(1'b0, 1'b1, 1'b1, 32'd1);
      sample(1'b1, 1'b1, 1'b1, 32'd1);
      read_op(OP_READ_POS);
      read_op(OP_READ_DIR);
      read_op(OP_READ_DIR);
      sample(1'b0, 1'b1, 1'b1, 32'd5);   // A falls then rises: no detent
      sample(1'b1, 1'b1, 1'b1, 32'd5);
      sample(1'b1, 1'b1, 1'b0, 32'd100); // press accepted
      sample(1'b1, 1'b1, 1'b1, 32'd101);
      sample(1'b1, 1'b1, 1'b0, 32'd102); // inside window
      sample(1'b1, 1'b1, 1'b1, 32'd110);
      sample(1'b1, 1'b1, 1'b0, 32'd110); // window elapsed
      sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_beat('1);                      // unused opcode, all fields high
      cur_a = 1'b1;
      cur_b = 1'b1;
      cur_btn = 1'b1;
      clock_ms = 32'd200;

      run_phase(1'b1, 16'd0, 15);
      run_phase(1'b1, 16'hFFFF, 15);
      run_phase(1'b0, 16'd17, 15);

      // long clockwise spin to wrap the signed position
      drain(6);
      write_reg(CSR_BUTTON_ENABLE, 16'd1);
      write_reg(CSR_DEBOUNCE_MS, 16'd20);
      read_op(OP_READ_POS);
      repeat (130) turn(1'b1, 1'b0, 1'b0);
      read_op(OP_READ_POS);
      repeat (3) turn(1'b0, 1'b0, 1'b0);
      read_op(OP_READ_POS);

      no_idle = 1'b1;
      run_phase(1'b1, 16'd200, 15);

      drain(8);
      if (meter.pending.size() != 0) meter.report("leftover beats", meter.pending.size(), 0);
      if (meter.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/qkd_pkg.sv
rtl/qkd_track.sv
rtl/qkd_button.sv
rtl/quadrature_knob_decoder.sv
tb/tb_quadrature_knob_decoder.sv
